// ----- sv/stni_pkg.sv -----
// ----------------------------------------------------------------------------
// stni_pkg
// Types and constants shared by the sorted top-N insertion table.
// ----------------------------------------------------------------------------
package stni_pkg;

   localparam int DEPTH  = 64;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;
   localparam int SIZE_W = 7;
   localparam int KEY_W  = 32;
   localparam int TAG_W  = 16;

   localparam int REQ_DATA_W = 56;
   localparam int RES_W      = 1 + IDX_W + 1 + KEY_W + TAG_W + 1 + KEY_W + TAG_W;
   localparam int RSP_DATA_W = 112;
   localparam int RSP_PAD_W  = RSP_DATA_W - RES_W;

   typedef enum logic {
      OP_OFFER = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic {
      REG_SIZE_IN_USE     = 1'b0,
      REG_LOWER_IS_BETTER = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef struct packed {
      op_type           op;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
      logic [IDX_W-1:0] idx;
   } job_type;

   // packed MSB first: accepted lands in bit 0
   typedef struct packed {
      logic [TAG_W-1:0] read_tag;
      logic [KEY_W-1:0] read_key;
      logic             read_valid;
      logic [TAG_W-1:0] evicted_tag;
      logic [KEY_W-1:0] evicted_key;
      logic             evicted_valid;
      logic [IDX_W-1:0] slot;
      logic             accepted;
   } result_type;

   // size of 0 acts as 1, above DEPTH acts as DEPTH
   function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [CNT_W-1:0] r;
      r = CNT_W'(s);
      if (s == '0) begin
         r = CNT_W'(1);
      end else if (CNT_W'(s) > CNT_W'(DEPTH)) begin
         r = CNT_W'(DEPTH);
      end
      return r;
   endfunction

endpackage

// ----- sv/stni_walk.sv -----
// ----------------------------------------------------------------------------
// stni_walk
// Slot memory, fill count and the sequencer that walks it: one slot per
// cycle through a single key comparator, inserting and rippling entries down.
// ----------------------------------------------------------------------------
module stni_walk (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  stni_pkg::csr_index_type     csr_index,
   input  logic [stni_pkg::SIZE_W-1:0] csr_wdata,
   input  logic                        start,
   input  stni_pkg::job_type           job,
   output logic                        idle,
   output logic                        res_valid,
   output stni_pkg::result_type        res,
   input  logic                        take
);
   import stni_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_READ,
      ST_HOLD
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              lib_ff, lib_in;
   logic              ins_ff, ins_in;
   entry_type         carry_ff, carry_in;
   job_type           job_ff, job_in;
   result_type        res_ff, res_in;

   entry_type         mem [DEPTH];
   entry_type         rd_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   logic [CNT_W-1:0]  size_eff;
   logic [CNT_W-1:0]  new_eff;
   logic              better;
   logic              p_valid;
   logic              at_end;

   assign size_eff = eff_size(size_ff);
   assign new_eff  = eff_size(csr_wdata);
   assign better   = lib_ff ? (rd_ff.key < job_ff.key) : (rd_ff.key > job_ff.key);
   assign p_valid  = ptr_ff < cnt_ff;
   assign at_end   = ptr_ff >= size_eff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      size_in  = size_ff;
      lib_in   = lib_ff;
      ins_in   = ins_ff;
      carry_in = carry_ff;
      job_in   = job_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = ptr_ff[IDX_W-1:0];
      wr_data  = ins_ff ? carry_ff : entry_type'({job_ff.key, job_ff.tag});
      rd_addr  = ptr_ff[IDX_W-1:0] + IDX_W'(1);

      if (csr_we) begin
         unique case (csr_index)
            REG_SIZE_IN_USE: begin
               size_in = csr_wdata;
               if (cnt_ff > new_eff) begin
                  cnt_in = new_eff;
               end
            end
            REG_LOWER_IS_BETTER: begin
               lib_in = csr_wdata[0];
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = (job.op == OP_READ) ? job.idx : '0;
            if (start) begin
               job_in   = job;
               ptr_in   = '0;
               ins_in   = 1'b0;
               res_in   = '0;
               state_in = (job.op == OP_READ) ? ST_READ : ST_WALK;
            end
         end
         ST_READ: begin
            if ({1'b0, job_ff.idx} < cnt_ff) begin
               res_in.read_valid = 1'b1;
               res_in.read_key   = rd_ff.key;
               res_in.read_tag   = rd_ff.tag;
            end
            state_in = ST_HOLD;
         end
         ST_WALK: begin
            if (!ins_ff) begin
               if (at_end) begin
                  // refused: report the offer itself
                  res_in.evicted_key = job_ff.key;
                  res_in.evicted_tag = job_ff.tag;
                  state_in           = ST_HOLD;
               end else if (p_valid && better) begin
                  ptr_in = ptr_ff + CNT_W'(1);
               end else begin
                  wr_en           = 1'b1;
                  ins_in          = 1'b1;
                  carry_in        = rd_ff;
                  res_in.accepted = 1'b1;
                  res_in.slot     = ptr_ff[IDX_W-1:0];
                  if (!p_valid) begin
                     cnt_in   = cnt_ff + CNT_W'(1);
                     state_in = ST_HOLD;
                  end else begin
                     ptr_in = ptr_ff + CNT_W'(1);
                  end
               end
            end else begin
               if (at_end) begin
                  res_in.evicted_valid = 1'b1;
                  res_in.evicted_key   = carry_ff.key;
                  res_in.evicted_tag   = carry_ff.tag;
                  state_in             = ST_HOLD;
               end else begin
                  wr_en    = 1'b1;
                  carry_in = rd_ff;
                  if (!p_valid) begin
                     cnt_in   = cnt_ff + CNT_W'(1);
                     state_in = ST_HOLD;
                  end else begin
                     ptr_in = ptr_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_HOLD: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         size_ff  <= SIZE_W'(DEPTH);
         lib_ff   <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         size_ff  <= size_in;
         lib_ff   <= lib_in;
      end
      ptr_ff   <= ptr_in;
      ins_ff   <= ins_in;
      carry_ff <= carry_in;
      job_ff   <= job_in;
      res_ff   <= res_in;
   end

   assign idle      = state_ff == ST_IDLE;
   assign res_valid = state_ff == ST_HOLD;
   assign res       = res_ff;

   a_cnt_in_size: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= size_eff)
      else $error("fill count beyond table size");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> ptr_ff <= size_eff)
      else $error("walk pointer past last slot");

   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD && !take |=> state_ff == ST_HOLD && $stable(res_ff))
      else $error("result changed before transfer");

   a_offer_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && start && job.op == OP_OFFER
      |=> state_ff == ST_WALK && ptr_ff == '0 && !ins_ff)
      else $error("offer walk did not start at slot zero");

endmodule

// ----- sv/sorted_topn_insert.sv -----
// ----------------------------------------------------------------------------
// sorted_topn_insert
// Table of up to 64 key/tag entries kept sorted best first; offers insert
// and evict the worst, reads return one slot.
// ----------------------------------------------------------------------------
//
//   channel | dir | ports         | transfer
//   --------+-----+---------------+-----------------------------------------
//   req     | in  | req_t*        | offer or read op, tuser = op
//   rsp     | out | rsp_t*        | one result per request
//   csr     | in  | csr_*         | register write, index 0 size, 1 direction
//
// An offer walks the slots one per cycle through one comparator on a slot
// memory with one read and one write port. Synchronous reset empties the
// table at once.
// A new request is taken while the previous result waits on rsp_tready.
//
module sorted_topn_insert (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [31:0] fitness_key, [47:32] entry_tag, [53:48] read_index, rest zero
   input  logic [stni_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] accepted, [6:1] slot, [7] evicted_valid, [39:8] evicted_key,
   // [55:40] evicted_tag, [56] read_valid, [88:57] read_key,
   // [104:89] read_tag, rest zero
   output logic [stni_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  stni_pkg::csr_index_type         csr_index,
   input  logic [stni_pkg::SIZE_W-1:0]     csr_wdata
);
   import stni_pkg::*;

   job_type    job;
   logic       start;
   logic       idle;
   logic       res_valid;
   result_type res;
   logic       take;
   logic       rsp_valid_ff;
   result_type rsp_res_ff;

   assign job.op  = op_type'(req_tuser);
   assign job.key = req_tdata[KEY_W-1:0];
   assign job.tag = req_tdata[KEY_W+TAG_W-1:KEY_W];
   assign job.idx = req_tdata[KEY_W+TAG_W+IDX_W-1:KEY_W+TAG_W];

   assign req_tready = idle;
   assign start      = req_tvalid && idle;
   assign take       = res_valid && (!rsp_valid_ff || rsp_tready);

   stni_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .start     (start),
      .job       (job),
      .idle      (idle),
      .res_valid (res_valid),
      .res       (res),
      .take      (take)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_res_ff};

endmodule

// ----- dv/sorted_topn_insert_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_topn_insert_test
// Self-checking bench for the sorted top-N insertion table. A scoreboard
// keeps its own ranked copy of the table and the two registers, works out
// the response to every request transfer and checks each response transfer
// field by field. A short directed run covers empty reads, extreme keys and
// tags, ties, refusals, evictions at the last slot, out-of-range sizes and
// direction flips. Random traffic follows under changing settings, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module sorted_topn_insert_test;
   import stni_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 80;

   class topn_scoreboard;
      logic [KEY_W-1:0]  slot_key [DEPTH];
      logic [TAG_W-1:0]  slot_tag [DEPTH];
      bit                slot_valid [DEPTH];
      logic [SIZE_W-1:0] size_reg;
      bit                lower_better;
      result_type        expected_results [$];
      int                mismatches;

      function new();
         size_reg     = SIZE_W'(DEPTH);
         lower_better = 1'b1;
         mismatches   = 0;
         foreach (slot_valid[j]) slot_valid[j] = 1'b0;
      endfunction

      function int active_slots();
         if (size_reg == 0) return 1;
         if (int'(size_reg) > DEPTH) return DEPTH;
         return int'(size_reg);
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function bit ranks_ahead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
         return lower_better ? (a < b) : (a > b);
      endfunction

      function void write_register(csr_index_type idx, logic [SIZE_W-1:0] value);
         if (idx == REG_SIZE_IN_USE) begin
            size_reg = value;
            for (int j = active_slots(); j < DEPTH; j++) slot_valid[j] = 1'b0;
         end else begin
            lower_better = value[0];
         end
      endfunction

      function void note_request(job_type j);
         result_type r;
         int         n;
         int         pos;
         r = '0;
         n = active_slots();
         if (j.op == OP_READ) begin
            if (int'(j.idx) < n && slot_valid[j.idx]) begin
               r.read_valid = 1'b1;
               r.read_key   = slot_key[j.idx];
               r.read_tag   = slot_tag[j.idx];
            end
         end else begin
            pos = 0;
            while (pos < n && slot_valid[pos] && ranks_ahead(slot_key[pos], j.key)) pos++;
            if (pos >= n) begin
               // refused: the offer itself comes back
               r.evicted_key = j.key;
               r.evicted_tag = j.tag;
            end else begin
               if (slot_valid[n-1]) begin
                  r.evicted_valid = 1'b1;
                  r.evicted_key   = slot_key[n-1];
                  r.evicted_tag   = slot_tag[n-1];
               end
               for (int k = n - 1; k > pos; k--) begin
                  slot_key[k]   = slot_key[k-1];
                  slot_tag[k]   = slot_tag[k-1];
                  slot_valid[k] = slot_valid[k-1];
               end
               slot_key[pos]   = j.key;
               slot_tag[pos]   = j.tag;
               slot_valid[pos] = 1'b1;
               r.accepted      = 1'b1;
               r.slot          = IDX_W'(pos);
            end
         end
         expected_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %0s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) report_mismatch($sformatf("%0s got %0h want %0h", name, got, want));
      endtask

      task check_response(logic [RSP_DATA_W-1:0] data);
         result_type got;
         result_type want;
         got = result_type'(data[RES_W-1:0]);
         if (expected_results.size() == 0) begin
            report_mismatch("response transfer with no request outstanding");
         end else begin
            want = expected_results.pop_front();
            compare_field("accepted", 64'(got.accepted), 64'(want.accepted));
            compare_field("slot", 64'(got.slot), 64'(want.slot));
            compare_field("evicted_valid", 64'(got.evicted_valid),
                          64'(want.evicted_valid));
            compare_field("evicted_key", 64'(got.evicted_key), 64'(want.evicted_key));
            compare_field("evicted_tag", 64'(got.evicted_tag), 64'(want.evicted_tag));
            compare_field("read_valid", 64'(got.read_valid), 64'(want.read_valid));
            compare_field("read_key", 64'(got.read_key), 64'(want.read_key));
            compare_field("read_tag", 64'(got.read_tag), 64'(want.read_tag));
            compare_field("padding", 64'(data[RSP_DATA_W-1:RES_W]), '0);
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [SIZE_W-1:0]     csr_wdata;

   topn_scoreboard sb = new();
   int             send_idle_pct;
   int             rsp_idle_pct;
   int             cycle_count;

   sorted_topn_insert u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_topn_insert verification failed");
      $finish;
   end

   // response side: check each transfer, then pick next cycle's ready
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic job_type make_job(op_type op, logic [KEY_W-1:0] key,
                                        logic [TAG_W-1:0] tag, logic [IDX_W-1:0] idx);
      job_type j;
      j.op  = op;
      j.key = key;
      j.tag = tag;
      j.idx = idx;
      return j;
   endfunction

   function automatic job_type random_job();
      job_type j;
      int      n;
      n = sb.active_slots();
      j.op = ($urandom_range(99) < 30) ? OP_READ : OP_OFFER;
      case ($urandom_range(9))
         0:       j.key = '0;
         1:       j.key = '1;
         2, 3:    j.key = KEY_W'($urandom);
         4:       j.key = 32'hFFFF_FFF0 | KEY_W'($urandom_range(15));
         default: j.key = KEY_W'($urandom_range(15));
      endcase
      j.tag = TAG_W'($urandom);
      if ($urandom_range(99) < 80)
         j.idx = IDX_W'($urandom_range(n < DEPTH ? n : DEPTH - 1));
      else
         j.idx = IDX_W'($urandom);
      return j;
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return SIZE_W'($urandom_range(1, 8));
      if (pick < 70) return SIZE_W'($urandom_range(9, DEPTH - 1));
      if (pick < 82) return SIZE_W'(DEPTH);
      if (pick < 88) return '0;
      return SIZE_W'($urandom_range(DEPTH + 1, 127));
   endfunction

   task automatic send_item(input job_type j);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, j.idx, j.tag, j.key};
      req_tuser  <= j.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(j);
   endtask

   // both registers, written only once every response is back
   task automatic set_config(input logic [SIZE_W-1:0] size, input logic lower);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_SIZE_IN_USE;
      csr_wdata <= size;
      @(posedge clock);
      sb.write_register(REG_SIZE_IN_USE, size);
      csr_index <= REG_LOWER_IS_BETTER;
      csr_wdata <= SIZE_W'(lower);
      @(posedge clock);
      sb.write_register(REG_LOWER_IS_BETTER, SIZE_W'(lower));
      csr_we <= 1'b0;
   endtask

   initial begin
      int mode;
      int sent;
      int burst;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_OFFER;
      csr_we     <= 1'b0;
      csr_index  <= REG_SIZE_IN_USE;
      csr_wdata  <= '0;
      send_idle_pct = 20;
      rsp_idle_pct  = 54;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: full size, smaller key ranks better
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd0));
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd63));
      send_item(make_job(OP_OFFER, 32'hFFFF_FFFF, 16'h0000, 6'd0));
      send_item(make_job(OP_OFFER, 32'h0,         16'hFFFF, 6'd0));
      send_item(make_job(OP_OFFER, 32'h0,         16'h1234, 6'd0));
      send_item(make_job(OP_OFFER, 32'h7,         16'h00FF, 6'd0));
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd1));
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd3));

      // shrink to three slots: refusal, tie at the last slot, read past size
      set_config(7'd3, 1'b1);
      send_item(make_job(OP_OFFER, 32'hFFFF_FFFF, 16'h5555, 6'd0));
      send_item(make_job(OP_OFFER, 32'h7,         16'h0AAA, 6'd0));
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd3));
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd2));

      // size zero acts as one slot, larger key ranks better
      set_config(7'd0, 1'b0);
      send_item(make_job(OP_OFFER, 32'h0,         16'h0001, 6'd0));
      send_item(make_job(OP_OFFER, 32'h1,         16'hFFFF, 6'd0));
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd0));

      // oversize acts as full depth
      set_config(7'd127, 1'b0);
      send_item(make_job(OP_OFFER, 32'h8000_0000, 16'h8000, 6'd0));
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd63));
      send_item(make_job(OP_OFFER, 32'hFFFF_FFFF, 16'hFFFF, 6'd0));
      send_item(make_job(OP_READ,  32'h0,         16'h0,    6'd1));

      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 20;
               rsp_idle_pct  = 54;
            end
            1: begin
               send_idle_pct = 54;
               rsp_idle_pct  = 20;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
            end
         endcase
         sent = 0;
         while (sent < RANDOM_ITEMS / 3) begin
            set_config(random_size(), 1'($urandom_range(1)));
            burst = $urandom_range(40, 120);
            repeat (burst) begin
               send_item(random_job());
               sent++;
            end
         end
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("sorted_topn_insert verification clean");
      else
         $display("sorted_topn_insert verification failed");
      $finish;
   end

endmodule
